// ===== rtl/sha1_pkg.sv =====
// shared types, constants and tables of the sha-1 digest engine
package sha1_pkg;

   localparam int WORD_W       = 32;
   localparam int ROUNDS       = 80;
   localparam int ROUND_W      = 7;
   localparam int SCHED_WORDS  = 16;
   localparam int BLOCK_BYTES  = 64;
   localparam int BLOCK_W      = 512;
   localparam int CNT_W        = 6;
   localparam int LENGTH_POS   = 56;
   localparam int LEN_W        = 64;
   localparam int MSG_BYTES_W  = 61;
   localparam int DIGEST_WORDS = 5;
   localparam int WORD_IDX_W   = 3;
   localparam logic [7:0] PAD_MARK = 8'h80;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_COMPRESS,
      ST_UPDATE,
      ST_OUTPUT
   } state_type;

   typedef enum logic [1:0] {
      SRC_DATA,
      SRC_MARK,
      SRC_ZERO,
      SRC_LEN
   } byte_src_type;

   typedef struct packed {
      logic                    shift_byte;
      byte_src_type            byte_src;
      logic                    count_msg;
      logic                    latch_len;
      logic                    round_en;
      logic [ROUND_W-1:0]      round_idx;
      logic                    update_chain;
      logic                    restart;
      logic [WORD_IDX_W-1:0]   word_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic block_last_slot;
      logic length_slot;
   } dp_status_type;

   function automatic logic [WORD_W-1:0] chain_init(input logic [WORD_IDX_W-1:0] idx);
      logic [WORD_W-1:0] v;
      case (idx)
         3'd0:    v = 32'h67452301;
         3'd1:    v = 32'hEFCDAB89;
         3'd2:    v = 32'h98BADCFE;
         3'd3:    v = 32'h10325476;
         default: v = 32'hC3D2E1F0;
      endcase
      return v;
   endfunction

   function automatic logic [WORD_W-1:0] round_const(input logic [ROUND_W-1:0] t);
      logic [WORD_W-1:0] k;
      if (t < ROUND_W'(20)) begin
         k = 32'h5A827999;
      end else if (t < ROUND_W'(40)) begin
         k = 32'h6ED9EBA1;
      end else if (t < ROUND_W'(60)) begin
         k = 32'h8F1BBCDC;
      end else begin
         k = 32'hCA62C1D6;
      end
      return k;
   endfunction

endpackage

// ===== rtl/sha1_datapath.sv =====
// block shift register, message schedule, round unit, chaining words and length
module sha1_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [7:0]                           in_byte,
   input  sha1_pkg::dp_cmd_type                 cmd,
   output sha1_pkg::dp_status_type              status,
   output logic [sha1_pkg::WORD_W-1:0]          digest_word
);

   localparam int W = sha1_pkg::WORD_W;
   localparam int B = sha1_pkg::BLOCK_W;

   logic [B-1:0]                        blk_ff, blk_in;
   logic [sha1_pkg::CNT_W-1:0]          cnt_ff, cnt_in;
   logic [sha1_pkg::MSG_BYTES_W-1:0]    msg_bytes_ff, msg_bytes_in;
   logic [sha1_pkg::LEN_W-1:0]          len_ff, len_in;
   logic [W-1:0]                        chain_ff [0:sha1_pkg::DIGEST_WORDS-1];
   logic [W-1:0]                        chain_in [0:sha1_pkg::DIGEST_WORDS-1];
   logic [W-1:0]                        work_ff  [0:sha1_pkg::DIGEST_WORDS-1];
   logic [W-1:0]                        work_in  [0:sha1_pkg::DIGEST_WORDS-1];

   logic [7:0]   byte_mux;
   logic [W-1:0] a, b, c, d, e;
   logic [W-1:0] w0, w2, w8, w13, sched, wt, f, tmp;

   // byte source
   always_comb begin
      unique case (cmd.byte_src)
         sha1_pkg::SRC_DATA: byte_mux = in_byte;
         sha1_pkg::SRC_MARK: byte_mux = sha1_pkg::PAD_MARK;
         sha1_pkg::SRC_ZERO: byte_mux = 8'h00;
         sha1_pkg::SRC_LEN:  byte_mux = len_ff[sha1_pkg::LEN_W-1 -: 8];
         default:            byte_mux = 8'h00;
      endcase
   end

   // round 0 starts from the chaining words
   always_comb begin
      if (cmd.round_idx == '0) begin
         a = chain_ff[0]; b = chain_ff[1]; c = chain_ff[2]; d = chain_ff[3]; e = chain_ff[4];
      end else begin
         a = work_ff[0]; b = work_ff[1]; c = work_ff[2]; d = work_ff[3]; e = work_ff[4];
      end
   end

   // schedule window, word 0 in the top bits
   assign w0    = blk_ff[B-1       -: W];
   assign w2    = blk_ff[B-1-2*W   -: W];
   assign w8    = blk_ff[B-1-8*W   -: W];
   assign w13   = blk_ff[B-1-13*W  -: W];
   assign sched = w13 ^ w8 ^ w2 ^ w0;
   assign wt    = (cmd.round_idx < sha1_pkg::ROUND_W'(sha1_pkg::SCHED_WORDS)) ?
                  w0 : {sched[W-2:0], sched[W-1]};

   always_comb begin
      if (cmd.round_idx < sha1_pkg::ROUND_W'(20)) begin
         f = (b & c) | (~b & d);
      end else if (cmd.round_idx < sha1_pkg::ROUND_W'(40)) begin
         f = b ^ c ^ d;
      end else if (cmd.round_idx < sha1_pkg::ROUND_W'(60)) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
   end

   assign tmp = {a[W-6:0], a[W-1:W-5]} + f + e + sha1_pkg::round_const(cmd.round_idx) + wt;

   always_comb begin
      blk_in       = blk_ff;
      cnt_in       = cnt_ff;
      msg_bytes_in = msg_bytes_ff;
      len_in       = len_ff;
      for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
         work_in[i]  = work_ff[i];
         chain_in[i] = chain_ff[i];
      end
      if (cmd.shift_byte) begin
         blk_in = {blk_ff[B-9:0], byte_mux};
         cnt_in = cnt_ff + sha1_pkg::CNT_W'(1);
      end
      if (cmd.count_msg) begin
         msg_bytes_in = msg_bytes_ff + sha1_pkg::MSG_BYTES_W'(1);
      end
      if (cmd.latch_len) begin
         len_in = {msg_bytes_ff, 3'b000};
      end else if (cmd.shift_byte && cmd.byte_src == sha1_pkg::SRC_LEN) begin
         len_in = {len_ff[sha1_pkg::LEN_W-9:0], 8'h00};
      end
      if (cmd.round_en) begin
         blk_in     = {blk_ff[B-W-1:0], wt};
         work_in[0] = tmp;
         work_in[1] = a;
         work_in[2] = {b[1:0], b[W-1:2]};
         work_in[3] = c;
         work_in[4] = d;
      end
      if (cmd.update_chain) begin
         for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
      if (cmd.restart) begin
         cnt_in       = '0;
         msg_bytes_in = '0;
         for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
            chain_in[i] = sha1_pkg::chain_init(sha1_pkg::WORD_IDX_W'(i));
         end
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      len_ff <= len_in;
      for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
         work_ff[i] <= work_in[i];
      end
      if (reset) begin
         cnt_ff       <= '0;
         msg_bytes_ff <= '0;
         for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
            chain_ff[i] <= sha1_pkg::chain_init(sha1_pkg::WORD_IDX_W'(i));
         end
      end else begin
         cnt_ff       <= cnt_in;
         msg_bytes_ff <= msg_bytes_in;
         for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
            chain_ff[i] <= chain_in[i];
         end
      end
   end

   assign status.block_last_slot = (cnt_ff == sha1_pkg::CNT_W'(sha1_pkg::BLOCK_BYTES - 1));
   assign status.length_slot     = (cnt_ff == sha1_pkg::CNT_W'(sha1_pkg::LENGTH_POS));
   assign digest_word            = chain_ff[cmd.word_sel];

endmodule

// ===== rtl/sha1_ctrl.sv =====
// controller: byte intake, padding sequence, round count and digest output
module sha1_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic                                 in_byte_valid,
   input  logic                                 in_last,
   output logic                                 in_ready,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic                                 out_last,
   output logic [sha1_pkg::WORD_IDX_W-1:0]      out_index,
   input  sha1_pkg::dp_status_type              status,
   output sha1_pkg::dp_cmd_type                 cmd
);

   localparam logic [sha1_pkg::ROUND_W-1:0]    LAST_ROUND =
      sha1_pkg::ROUND_W'(sha1_pkg::ROUNDS - 1);
   localparam logic [sha1_pkg::WORD_IDX_W-1:0] LAST_WORD  =
      sha1_pkg::WORD_IDX_W'(sha1_pkg::DIGEST_WORDS - 1);

   sha1_pkg::state_type                 state_ff, state_in;
   sha1_pkg::state_type                 resume_ff, resume_in;
   logic [sha1_pkg::ROUND_W-1:0]        round_ff, round_in;
   logic [sha1_pkg::WORD_IDX_W-1:0]     word_ff, word_in;

   // next state
   always_comb begin
      state_in  = state_ff;
      resume_in = resume_ff;
      round_in  = '0;
      word_in   = word_ff;
      unique case (state_ff)
         sha1_pkg::ST_IDLE: begin
            if (in_valid) begin
               if (in_byte_valid && status.block_last_slot) begin
                  state_in  = sha1_pkg::ST_COMPRESS;
                  resume_in = in_last ? sha1_pkg::ST_PAD_MARK : sha1_pkg::ST_IDLE;
               end else if (in_last) begin
                  state_in = sha1_pkg::ST_PAD_MARK;
               end
            end
         end
         sha1_pkg::ST_PAD_MARK: begin
            if (status.block_last_slot) begin
               state_in  = sha1_pkg::ST_COMPRESS;
               resume_in = sha1_pkg::ST_PAD_ZERO;
            end else begin
               state_in = sha1_pkg::ST_PAD_ZERO;
            end
         end
         sha1_pkg::ST_PAD_ZERO: begin
            if (status.length_slot) begin
               state_in = sha1_pkg::ST_PAD_LEN;
            end else if (status.block_last_slot) begin
               state_in  = sha1_pkg::ST_COMPRESS;
               resume_in = sha1_pkg::ST_PAD_ZERO;
            end
         end
         sha1_pkg::ST_PAD_LEN: begin
            if (status.block_last_slot) begin
               state_in  = sha1_pkg::ST_COMPRESS;
               resume_in = sha1_pkg::ST_OUTPUT;
            end
         end
         sha1_pkg::ST_COMPRESS: begin
            if (round_ff == LAST_ROUND) begin
               state_in = sha1_pkg::ST_UPDATE;
            end else begin
               round_in = round_ff + sha1_pkg::ROUND_W'(1);
            end
         end
         sha1_pkg::ST_UPDATE: begin
            state_in = resume_ff;
         end
         sha1_pkg::ST_OUTPUT: begin
            if (out_ready) begin
               if (word_ff == LAST_WORD) begin
                  state_in = sha1_pkg::ST_IDLE;
                  word_in  = '0;
               end else begin
                  word_in = word_ff + sha1_pkg::WORD_IDX_W'(1);
               end
            end
         end
         default: state_in = sha1_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath commands
   always_comb begin
      in_ready  = 1'b0;
      out_valid = 1'b0;
      cmd       = '0;
      cmd.byte_src  = sha1_pkg::SRC_DATA;
      cmd.round_idx = round_ff;
      cmd.word_sel  = word_ff;
      unique case (state_ff)
         sha1_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid && in_byte_valid) begin
               cmd.shift_byte = 1'b1;
               cmd.count_msg  = 1'b1;
            end
         end
         sha1_pkg::ST_PAD_MARK: begin
            cmd.shift_byte = 1'b1;
            cmd.byte_src   = sha1_pkg::SRC_MARK;
            cmd.latch_len  = 1'b1;
         end
         sha1_pkg::ST_PAD_ZERO: begin
            cmd.shift_byte = !status.length_slot;
            cmd.byte_src   = sha1_pkg::SRC_ZERO;
         end
         sha1_pkg::ST_PAD_LEN: begin
            cmd.shift_byte = 1'b1;
            cmd.byte_src   = sha1_pkg::SRC_LEN;
         end
         sha1_pkg::ST_COMPRESS: begin
            cmd.round_en = 1'b1;
         end
         sha1_pkg::ST_UPDATE: begin
            cmd.update_chain = 1'b1;
         end
         sha1_pkg::ST_OUTPUT: begin
            out_valid   = 1'b1;
            cmd.restart = out_ready && (word_ff == LAST_WORD);
         end
         default: ;
      endcase
   end

   assign out_index = word_ff;
   assign out_last  = (word_ff == LAST_WORD);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sha1_pkg::ST_IDLE;
         resume_ff <= sha1_pkg::ST_IDLE;
         round_ff  <= '0;
         word_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         resume_ff <= resume_in;
         round_ff  <= round_in;
         word_ff   <= word_in;
      end
   end

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == sha1_pkg::ST_COMPRESS |-> round_ff <= LAST_ROUND)
      else $error("round counter past last round");

   a_update_after_rounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == sha1_pkg::ST_UPDATE |->
         $past(state_ff) == sha1_pkg::ST_COMPRESS && $past(round_ff) == LAST_ROUND)
      else $error("chain update without a full set of rounds");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(in_ready && out_valid))
      else $error("intake open while digest pending");

   a_word_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> word_ff <= LAST_WORD)
      else $error("digest word index out of range");

   a_round_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != sha1_pkg::ST_COMPRESS |-> round_ff == '0)
      else $error("round counter not cleared outside compression");

endmodule

// ===== rtl/sha1_message_digest.sv =====
// intake: each accepted byte is shifted in; a filled block runs 80 rounds, one per cycle, and a
// chain add, with intake paused. finish: 0x80 mark, zero fill up to byte 56, a turn step that
// shifts nothing, 8 length bytes at one byte per cycle, then the rounds and chain add per block
// (two blocks when 56 or more bytes are pending), and the 5 digest words, each held until taken
// reset: synchronous, active high; chain returns to the sha-1 initial values, counts clear
// one message at a time: no new input transaction while padding, compressing or emitting
module sha1_message_digest (
   input  logic                                 clock,
   input  logic                                 reset,
   // input stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // [7:0] data_byte
   input  logic                                 req_tuser,  // [0] byte_valid
   input  logic                                 req_tlast,  // end_of_message
   // digest stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [sha1_pkg::WORD_W-1:0]          rsp_tdata,  // [31:0] digest_word
   output logic [sha1_pkg::WORD_IDX_W-1:0]      rsp_tuser,  // [2:0] word_index
   output logic                                 rsp_tlast   // last_word
);

   sha1_pkg::dp_cmd_type     cmd;
   sha1_pkg::dp_status_type  status;

   // sequencer: intake, padding, round count and output word index
   sha1_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_byte_valid (req_tuser),
      .in_last       (req_tlast),
      .in_ready      (req_tready),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_last      (rsp_tlast),
      .out_index     (rsp_tuser),
      .status        (status),
      .cmd           (cmd)
   );

   // datapath: block register doubles as the 16-word schedule window
   sha1_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .in_byte     (req_tdata),
      .cmd         (cmd),
      .status      (status),
      .digest_word (rsp_tdata)
   );

endmodule
